[rtl/core/sha256c_pkg.sv]
// Shared types, round constants and mixing functions for the SHA-256 block compression core.
package sha256c_pkg;

	typedef struct packed {
		logic [31:0] message_word;
		logic        end_of_message;
	} in_t;

	typedef struct packed {
		logic [31:0] digest_word0;
		logic [31:0] digest_word1;
		logic [31:0] digest_word2;
		logic [31:0] digest_word3;
		logic [31:0] digest_word4;
		logic [31:0] digest_word5;
		logic [31:0] digest_word6;
		logic [31:0] digest_word7;
	} out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_word;
		logic       init_vars;
		logic       do_round;
		logic       finish;
		logic       last;
		logic [5:0] round_idx;
	} cmd_t;

	localparam int unsigned WORDS_PER_BLOCK = 16;
	localparam int unsigned ROUNDS = 64;

	function automatic logic [31:0] init_hash(input logic [2:0] idx);
		logic [31:0] h;
		case (idx)
			3'd0: h = 32'h6a09e667;
			3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372;
			3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f;
			3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab;
			3'd7: h = 32'h5be0cd19;
			default: h = '0;
		endcase
		return h;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k;
		case (idx)
			6'd0:  k = 32'h428a2f98;
			6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;
			6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;
			6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;
			6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;
			6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;
			6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;
			6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;
			6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;
			6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;
			6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;
			6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;
			6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;
			6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;
			6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;
			6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;
			6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;
			6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;
			6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;
			6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;
			6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;
			6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;
			6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

[rtl/core/sha256c_ctrl.sv]
// Sequencer for word collection, the 64 compression rounds and the chain update.
module sha256c_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                end_of_message,
	output logic                busy,
	output logic                done,
	output sha256c_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_ROUNDS,
		ST_FINISH
	} state_t;

	state_t     state_q;
	logic [3:0] word_cnt_q;
	logic [5:0] round_q;
	logic       last_q;
	logic       done_q;
	logic       accept;
	logic       block_full;

	assign busy       = (state_q != ST_COLLECT);
	assign done       = done_q;
	assign accept     = start && !busy;
	assign block_full = (word_cnt_q == 4'(sha256c_pkg::WORDS_PER_BLOCK - 1));

	always_comb begin
		cmd.load_word = accept;
		// The working variables take the chain while the last word of the block goes in.
		cmd.init_vars = accept && block_full;
		cmd.do_round  = (state_q == ST_ROUNDS);
		cmd.finish    = (state_q == ST_FINISH);
		cmd.last      = last_q;
		cmd.round_idx = round_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_COLLECT;
			word_cnt_q <= '0;
			round_q    <= '0;
			last_q     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_COLLECT: begin
					if (accept) begin
						word_cnt_q <= word_cnt_q + 4'd1;
						if (block_full) begin
							last_q  <= end_of_message;
							round_q <= '0;
							state_q <= ST_ROUNDS;
						end
					end
				end
				ST_ROUNDS: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'(sha256c_pkg::ROUNDS - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					done_q  <= last_q;
					state_q <= ST_COLLECT;
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

endmodule

[rtl/core/sha256c_dp.sv]
// Message schedule window, round unit, chaining hash and digest register.
module sha256c_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  sha256c_pkg::cmd_t   cmd,
	input  logic [31:0]         word,
	output sha256c_pkg::out_t   result
);

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [31:0] digest_q [8];

	logic [31:0] sched_next;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] choose;
	logic [31:0] major;
	logic [31:0] sums [8];

	// The window always holds the next 16 schedule words; w_q[0] feeds the current round.
	assign sched_next = sha256c_pkg::small_sigma1(w_q[14]) + w_q[9]
		+ sha256c_pkg::small_sigma0(w_q[1]) + w_q[0];

	assign choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1     = v_q[7] + sha256c_pkg::big_sigma1(v_q[4]) + choose
		+ sha256c_pkg::round_k(cmd.round_idx) + w_q[0];
	assign t2     = sha256c_pkg::big_sigma0(v_q[0]) + major;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			sums[i] = h_q[i] + v_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_word || cmd.do_round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= cmd.load_word ? word : sched_next;
		end
		if (cmd.init_vars) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (cmd.do_round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (cmd.finish) begin
			for (int i = 0; i < 8; i++) begin
				digest_q[i] <= sums[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha256c_pkg::init_hash(3'(i));
			end
		end else if (cmd.finish) begin
			// After a final block the chain starts over for the next message.
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= cmd.last ? sha256c_pkg::init_hash(3'(i)) : sums[i];
			end
		end
	end

	assign result.digest_word0 = digest_q[0];
	assign result.digest_word1 = digest_q[1];
	assign result.digest_word2 = digest_q[2];
	assign result.digest_word3 = digest_q[3];
	assign result.digest_word4 = digest_q[4];
	assign result.digest_word5 = digest_q[5];
	assign result.digest_word6 = digest_q[6];
	assign result.digest_word7 = digest_q[7];

endmodule

[rtl/core/sha256_block_compression.sv]
// SHA-256 block compression core: words 1 to 15 of a block are taken one per cycle without busy.
// The 16th word raises busy for the 64 rounds on the single round unit and then the chain add.
// The digest strobe follows the chain add, for one cycle only, and only after a block marked end of message.
// Reset clears the sequencer and word count and loads the chain with the initial hash values.
module sha256_block_compression (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sha256c_pkg::in_t   data,
	output logic               done,
	output sha256c_pkg::out_t  result
);

	sha256c_pkg::cmd_t cmd;

	sha256c_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.end_of_message (data.end_of_message),
		.busy           (busy),
		.done           (done),
		.cmd            (cmd)
	);

	sha256c_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.word   (data.message_word),
		.result (result)
	);

endmodule
